// File: hw/rtl/binary_trie_prefix_table_defines.svh
// Assertion macros for the binary trie prefix table.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef BINARY_TRIE_PREFIX_TABLE_DEFINES_SVH
`define BINARY_TRIE_PREFIX_TABLE_DEFINES_SVH

// same-cycle implication
`define BTPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/btpt_pkg.sv
// Shared constants for the binary trie prefix table.
// No dependencies; imported by binary_trie_prefix_table.
package btpt_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int ADDR_BITS_DEF  = 32;

  localparam int OP_W   = 2;
  localparam int LEN_W  = 6;
  localparam int HOP_W  = 16;
  localparam int STAT_W = 2;

  // result beat: found_hop, status, padded to whole bytes
  localparam int OUT_TDATA_W = ((HOP_W + STAT_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd0;
  localparam logic [OP_W-1:0] OP_ANNOUNCE = 2'd1;
  localparam logic [OP_W-1:0] OP_WITHDRAW = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

endpackage

// File: hw/rtl/binary_trie_prefix_table.sv
// Binary trie longest-prefix-match route table, top level.
// Depends on btpt_pkg and binary_trie_prefix_table_defines.svh.
//
//  channel | dir | fields (low bit up)
//  --------+-----+-------------------------------------------------
//  in_*    | in  | tdata: op, address, prefix_len, next_hop
//  out_*   | out | tdata: found_hop, status
//  cfg_*   | in  | wdata: default_port (write only)
//
// Flow: one beat per item; accept in the idle state, then one walk step per trie level
// (up to ADDR_BITS+1 levels for lookup, prefix_len+1 for announce/withdraw), then
// the finish state loads the output register; only then does in_tready rise again.
// The level walk is bound by the single node memory read port, one node per cycle.
// Clear goes straight to the finish state. Reset: root node and pool counter cleared at once,
// no memory sweep. A stalled output holds the block in its finish state.
`include "binary_trie_prefix_table_defines.svh"

module binary_trie_prefix_table #(
  parameter int NODE_COUNT = btpt_pkg::NODE_COUNT_DEF,
  parameter int ADDR_BITS  = btpt_pkg::ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // op, address, prefix_len, next_hop, zero pad
  input  logic [((btpt_pkg::OP_W + ADDR_BITS + btpt_pkg::LEN_W + btpt_pkg::HOP_W + 7) / 8) * 8
                - 1:0]                        in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // found_hop, status, zero pad
  output logic [btpt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_wen,
  input  logic [btpt_pkg::HOP_W-1:0]          cfg_wdata
);
  import btpt_pkg::*;

  localparam int IDX_W   = $clog2(NODE_COUNT);
  localparam int FREE_W  = IDX_W + 1;
  localparam int LVL_W   = $clog2(ADDR_BITS + 1);
  localparam int ENTRY_W = 2 * IDX_W + HOP_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // input beat fields
  logic [OP_W-1:0]      in_op;
  logic [ADDR_BITS-1:0] in_addr;
  logic [LEN_W-1:0]     in_len;
  logic [HOP_W-1:0]     in_hop;
  logic [LVL_W-1:0]     len_clamped;

  assign in_op   = in_tdata[OP_W-1:0];
  assign in_addr = in_tdata[OP_W +: ADDR_BITS];
  assign in_len  = in_tdata[OP_W + ADDR_BITS +: LEN_W];
  assign in_hop  = in_tdata[OP_W + ADDR_BITS + LEN_W +: HOP_W];
  assign len_clamped = (32'(in_len) > ADDR_BITS) ? LVL_W'(ADDR_BITS) : LVL_W'(in_len);

  // control and item registers
  logic [1:0]           state_r, state_nxt;
  logic [OP_W-1:0]      op_r;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [LVL_W-1:0]     len_r;
  logic [LVL_W-1:0]     level_r, level_nxt;
  logic [HOP_W-1:0]     hop_r;
  logic [IDX_W-1:0]     node_r, node_nxt;
  logic                 fresh_r, fresh_nxt;
  logic [FREE_W-1:0]    free_r, free_nxt;
  logic [HOP_W-1:0]     best_r, best_nxt;
  logic [STAT_W-1:0]    stat_r, stat_nxt;
  logic [HOP_W-1:0]     default_port_r;

  // root node lives in flops so reset clears it
  logic [IDX_W-1:0]     root_left_r, root_left_nxt;
  logic [IDX_W-1:0]     root_right_r, root_right_nxt;
  logic [HOP_W-1:0]     root_hop_r, root_hop_nxt;

  // output register
  logic                 out_valid_r;
  logic [HOP_W-1:0]     out_hop_r;
  logic [STAT_W-1:0]    out_stat_r;
  logic                 out_load;

  // node memory, entries 1..NODE_COUNT-1 used
  logic [ENTRY_W-1:0]   node_mem [NODE_COUNT];
  logic [ENTRY_W-1:0]   mem_q;
  logic [IDX_W-1:0]     mem_raddr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= node_mem[mem_raddr];
  end

  // current node: root flops, a freshly taken (zero) node, or the memory word
  logic [IDX_W-1:0] cur_left, cur_right, child;
  logic [HOP_W-1:0] cur_hop;
  logic             dir_bit, at_len, pool_full;

  always_comb begin
    if (node_r == '0) begin
      cur_left  = root_left_r;
      cur_right = root_right_r;
      cur_hop   = root_hop_r;
    end else if (fresh_r) begin
      cur_left  = '0;
      cur_right = '0;
      cur_hop   = '0;
    end else begin
      cur_left  = mem_q[IDX_W-1:0];
      cur_right = mem_q[2*IDX_W-1:IDX_W];
      cur_hop   = mem_q[ENTRY_W-1:2*IDX_W];
    end
  end

  assign dir_bit   = addr_r[ADDR_BITS-1];
  assign child     = dir_bit ? cur_right : cur_left;
  assign at_len    = (level_r == len_r);
  assign pool_full = (free_r == FREE_W'(NODE_COUNT));

  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    level_nxt      = level_r;
    node_nxt       = node_r;
    fresh_nxt      = fresh_r;
    free_nxt       = free_r;
    best_nxt       = best_r;
    stat_nxt       = stat_r;
    root_left_nxt  = root_left_r;
    root_right_nxt = root_right_r;
    root_hop_nxt   = root_hop_r;
    mem_raddr      = child;
    mem_we         = 1'b0;
    mem_waddr      = node_r;
    mem_wdata      = {cur_hop, cur_right, cur_left};

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          addr_nxt  = in_addr;
          level_nxt = '0;
          node_nxt  = '0;
          fresh_nxt = 1'b0;
          best_nxt  = '0;
          stat_nxt  = STAT_DONE;
          if (in_op == OP_CLEAR) begin
            root_left_nxt  = '0;
            root_right_nxt = '0;
            root_hop_nxt   = default_port_r;
            free_nxt       = FREE_W'(1);
            state_nxt      = ST_FINISH;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        case (op_r)
          OP_LOOKUP: begin
            if (cur_hop != '0) begin
              best_nxt = cur_hop;
            end
            if (level_r == LVL_W'(ADDR_BITS) || child == '0) begin
              state_nxt = ST_FINISH;
            end else begin
              node_nxt  = child;
              addr_nxt  = addr_r << 1;
              level_nxt = level_r + 1'b1;
            end
          end

          OP_ANNOUNCE: begin
            if (at_len) begin
              // set the hop of the final node
              if (node_r == '0) begin
                root_hop_nxt = hop_r;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = {hop_r, cur_right, cur_left};
              end
              state_nxt = ST_FINISH;
            end else if (child != '0) begin
              node_nxt  = child;
              addr_nxt  = addr_r << 1;
              level_nxt = level_r + 1'b1;
            end else if (pool_full) begin
              // a node taken earlier on this walk still needs its zero entry
              mem_we    = fresh_r;
              mem_wdata = '0;
              stat_nxt  = STAT_FULL;
              state_nxt = ST_FINISH;
            end else begin
              // link a new node; it is zero until its own entry is written
              if (node_r == '0) begin
                if (dir_bit) begin
                  root_right_nxt = free_r[IDX_W-1:0];
                end else begin
                  root_left_nxt = free_r[IDX_W-1:0];
                end
              end else begin
                mem_we    = 1'b1;
                mem_wdata = dir_bit ? {cur_hop, free_r[IDX_W-1:0], cur_left}
                                    : {cur_hop, cur_right, free_r[IDX_W-1:0]};
              end
              node_nxt  = free_r[IDX_W-1:0];
              fresh_nxt = 1'b1;
              free_nxt  = free_r + 1'b1;
              addr_nxt  = addr_r << 1;
              level_nxt = level_r + 1'b1;
            end
          end

          OP_WITHDRAW: begin
            if (at_len) begin
              if (node_r == '0) begin
                root_hop_nxt = '0;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = {{HOP_W{1'b0}}, cur_right, cur_left};
              end
              state_nxt = ST_FINISH;
            end else if (child == '0) begin
              stat_nxt  = STAT_MISSING;
              state_nxt = ST_FINISH;
            end else begin
              node_nxt  = child;
              addr_nxt  = addr_r << 1;
              level_nxt = level_r + 1'b1;
            end
          end

          default: begin
            state_nxt = ST_FINISH;
          end
        endcase
      end

      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      free_r         <= FREE_W'(1);
      root_left_r    <= '0;
      root_right_r   <= '0;
      root_hop_r     <= '0;
      default_port_r <= '0;
      fresh_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_r       <= free_nxt;
      root_left_r  <= root_left_nxt;
      root_right_r <= root_right_nxt;
      root_hop_r   <= root_hop_nxt;
      fresh_r      <= fresh_nxt;
      if (cfg_wen) begin
        default_port_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    level_r <= level_nxt;
    node_r  <= node_nxt;
    best_r  <= best_nxt;
    stat_r  <= stat_nxt;
    if (in_tvalid && in_tready) begin
      op_r  <= in_op;
      len_r <= len_clamped;
      hop_r <= in_hop;
    end
    if (out_load) begin
      out_hop_r  <= best_r;
      out_stat_r <= stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - HOP_W - STAT_W){1'b0}}, out_stat_r, out_hop_r};

  // checks
  `BTPT_ASSERT_NEXT(a_clear_resets_pool, in_tvalid && in_tready && in_op == OP_CLEAR,
    free_r == FREE_W'(1) && root_hop_r == $past(default_port_r), "clear did not reset table")
  `BTPT_ASSERT_NOW(a_missing_only_withdraw, state_r == ST_FINISH && stat_r == STAT_MISSING,
    op_r == OP_WITHDRAW, "missing-path status on a non-withdraw beat")
  `BTPT_ASSERT_NOW(a_hop_only_lookup, state_r == ST_FINISH && best_r != '0,
    op_r == OP_LOOKUP, "nonzero found hop on a non-lookup beat")
  `BTPT_ASSERT_NOW(a_fresh_only_announce, state_r == ST_WALK && fresh_r,
    op_r == OP_ANNOUNCE && node_r != '0, "fresh node outside an announce walk")
  `BTPT_ASSERT_NEXT(a_pool_monotone, state_r == ST_WALK,
    free_r >= $past(free_r) && free_r <= FREE_W'(NODE_COUNT), "pool counter out of order")

endmodule

// File: tb/sv/binary_trie_prefix_table_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for binary_trie_prefix_table: route ops go in as stream beats and
// a trie predictor kept here forecasts each result beat. Depends on btpt_pkg and the RTL.
module binary_trie_prefix_table_tb;
  import btpt_pkg::*;

  localparam int NODES        = NODE_COUNT_DEF;
  localparam int AW           = ADDR_BITS_DEF;
  localparam int IN_W         = ((OP_W + AW + LEN_W + HOP_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;     // covers the worst walk plus output slack
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int PRINT_CAP    = 50;

  typedef enum int {MIX_ROUTES, MIX_FILL} mix_t;

  typedef struct packed {
    logic [HOP_W-1:0]  found_hop;
    logic [STAT_W-1:0] status;
  } route_res_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  wire                    in_tready;
  // op, address, prefix_len, next_hop
  logic [IN_W-1:0]        in_tdata   = '0;
  wire                    out_tvalid;
  logic                   out_tready = 1'b0;
  // found_hop, status, zero pad
  wire [OUT_TDATA_W-1:0]  out_tdata;
  logic                   cfg_wen    = 1'b0;
  logic [HOP_W-1:0]       cfg_wdata  = '0;

  binary_trie_prefix_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Trie predictor: own copy of the node memory, pool counter and default port.
  // ---------------------------------------------------------------------------
  int unsigned     left_tbl  [NODES];
  int unsigned     right_tbl [NODES];
  bit [HOP_W-1:0]  hop_tbl   [NODES];
  int unsigned     pool_next = 1;
  logic [HOP_W-1:0] dflt_port = '0;

  // Applies one op beat to the trie copy and returns the result it should produce.
  function automatic route_res_t route_apply(logic [IN_W-1:0] beat);
    logic [OP_W-1:0]  op;
    logic [AW-1:0]    addr;
    logic [LEN_W-1:0] plen;
    logic [HOP_W-1:0] hop;
    int unsigned      node, nxt;
    int               depth;
    route_res_t       res;
    {hop, plen, addr, op} = beat[OP_W+AW+LEN_W+HOP_W-1:0];
    res   = '{found_hop: '0, status: STAT_DONE};
    depth = (plen > AW) ? AW : int'(plen);   // over-long prefix saturates
    node  = 0;
    case (op)
      OP_LOOKUP: begin
        // keep the last nonzero hop along the longest existing path
        for (int lvl = 0; lvl <= AW; lvl++) begin
          if (hop_tbl[node] != 0) res.found_hop = hop_tbl[node];
          if (lvl == AW) break;
          nxt = addr[AW-1-lvl] ? right_tbl[node] : left_tbl[node];
          if (nxt == 0) break;
          node = nxt;
        end
      end
      OP_ANNOUNCE: begin
        for (int lvl = 0; lvl < depth && res.status == STAT_DONE; lvl++) begin
          nxt = addr[AW-1-lvl] ? right_tbl[node] : left_tbl[node];
          if (nxt == 0) begin
            if (pool_next >= NODES) begin
              res.status = STAT_FULL;    // nodes taken so far stay linked
            end else begin
              nxt = pool_next;
              pool_next++;
              left_tbl[nxt]  = 0;
              right_tbl[nxt] = 0;
              hop_tbl[nxt]   = '0;
              if (addr[AW-1-lvl]) right_tbl[node] = nxt;
              else left_tbl[node] = nxt;
            end
          end
          node = nxt;
        end
        if (res.status == STAT_DONE) hop_tbl[node] = hop;
      end
      OP_WITHDRAW: begin
        for (int lvl = 0; lvl < depth && res.status == STAT_DONE; lvl++) begin
          nxt = addr[AW-1-lvl] ? right_tbl[node] : left_tbl[node];
          if (nxt == 0) res.status = STAT_MISSING;
          node = nxt;
        end
        if (res.status == STAT_DONE) hop_tbl[node] = '0;
      end
      default: begin
        left_tbl[0]  = 0;
        right_tbl[0] = 0;
        hop_tbl[0]   = dflt_port;
        pool_next    = 1;
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus bookkeeping
  // ---------------------------------------------------------------------------
  logic [IN_W-1:0] op_beat_q [$];       // beats waiting for the driver
  route_res_t      route_due_q [$];     // predicted results, oldest first
  logic [AW-1:0]   known_addr [$];      // recently announced prefixes
  int              known_len [$];
  int              queued_cnt   = 0;
  int              results_seen = 0;
  int              err_cnt      = 0;
  int              cycle_cnt    = 0;
  bit              calm         = 1'b0; // no idling in the last part
  logic            long_hold    = 1'b0;
  logic            in_taken     = 1'b0;

  task automatic report_mismatch(string what);
    err_cnt++;
    if (err_cnt <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic logic [AW-1:0] prefix_mask(int len);
    return (len <= 0) ? '0 : ~{AW{1'b0}} << (AW - len);
  endfunction

  task automatic queue_item(logic [OP_W-1:0] op, logic [AW-1:0] addr,
                            logic [LEN_W-1:0] plen, logic [HOP_W-1:0] hop);
    op_beat_q.push_back({hop, plen, addr, op});
    queued_cnt++;
    if (op == OP_ANNOUNCE) begin
      known_addr.push_back(addr);
      known_len.push_back((plen > AW) ? AW : int'(plen));
      if (known_addr.size() > 64) begin
        void'(known_addr.pop_front());
        void'(known_len.pop_front());
      end
    end
  endtask

  // Mostly well-formed traffic: lookups and withdraws aim at announced prefixes.
  task automatic queue_random(mix_t mix);
    int               pick, k, len;
    logic [AW-1:0]    addr;
    logic [HOP_W-1:0] hop;
    pick = $urandom_range(0, 99);
    addr = $urandom;
    hop  = ($urandom_range(0, 19) == 0) ? '0 : HOP_W'($urandom);
    k    = (known_addr.size() > 0) ? $urandom_range(0, known_addr.size() - 1) : -1;
    if (mix == MIX_FILL && pick < 80) begin
      // long random prefixes burn through the node pool
      queue_item(OP_ANNOUNCE, addr, LEN_W'($urandom_range(28, AW)), hop);
    end else if (mix == MIX_ROUTES && pick < 40) begin
      len = $urandom_range(0, AW);
      if (k >= 0 && $urandom_range(0, 1) == 1) begin
        // more specific route under a known one
        addr = (known_addr[k] & prefix_mask(known_len[k])) | (addr & ~prefix_mask(known_len[k]));
        len  = $urandom_range(known_len[k], AW);
      end
      if ($urandom_range(0, 19) == 0) len = $urandom_range(AW + 1, 63);
      queue_item(OP_ANNOUNCE, addr, LEN_W'(len), hop);
    end else if (pick < 70 || (mix == MIX_FILL && pick < 95)) begin
      if (k >= 0 && $urandom_range(0, 3) != 0)
        addr = (known_addr[k] & prefix_mask(known_len[k])) | (addr & ~prefix_mask(known_len[k]));
      queue_item(OP_LOOKUP, addr, LEN_W'($urandom), HOP_W'($urandom));
    end else if (pick < 90 || mix == MIX_FILL) begin
      len = $urandom_range(0, 63);
      if (k >= 0 && $urandom_range(0, 9) < 7) begin
        addr = known_addr[k];
        len  = known_len[k];
      end
      queue_item(OP_WITHDRAW, addr, LEN_W'(len), hop);
    end else if (pick < 93) begin
      queue_item(OP_CLEAR, addr, LEN_W'($urandom), hop);
    end else begin
      // noise: every field random
      queue_item(OP_W'($urandom), addr, LEN_W'($urandom), hop);
    end
  endtask

  task automatic write_default_port(logic [HOP_W-1:0] port);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= port;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    dflt_port = port;
  endtask

  // Every queued beat answered, then let the walk pipeline settle.
  task automatic wait_drained();
    while (results_seen < queued_cnt) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(mix_t mix, int count, logic [HOP_W-1:0] port, bit lead_clear);
    write_default_port(port);
    if (lead_clear) queue_item(OP_CLEAR, $urandom, LEN_W'($urandom), HOP_W'($urandom));
    repeat (count) queue_random(mix);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one beat offered at a time, changed only on the falling edge.
  // ---------------------------------------------------------------------------
  int tx_gap = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (op_beat_q.size() > 0) begin
        in_tdata  <= op_beat_q.pop_front();
        in_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 16);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus the long hold-off below.
  int rx_stall = 0;

  always @(negedge clk) begin
    if (rx_stall == 0 && !calm && $urandom_range(0, 11) == 0) rx_stall = $urandom_range(1, 16);
    if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !long_hold;
    end
  end

  // Hold results back long enough that the block backs up and drops in_tready
  // while the driver keeps offering.
  initial begin
    wait (results_seen >= 60);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    long_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge. Results are checked
  // before the new beat is predicted; a beat's own result is never same-cycle.
  // ---------------------------------------------------------------------------
  route_res_t got_res, due_res;

  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got_res.found_hop = out_tdata[HOP_W-1:0];
      got_res.status    = out_tdata[HOP_W+STAT_W-1:HOP_W];
      if (route_due_q.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        due_res = route_due_q.pop_front();
        if (got_res.found_hop !== due_res.found_hop)
          report_mismatch($sformatf("found_hop %h, want %h",
                                    got_res.found_hop, due_res.found_hop));
        if (got_res.status !== due_res.status)
          report_mismatch($sformatf("status %0d, want %0d", got_res.status, due_res.status));
      end
    end
    if (rst_n && in_tvalid && in_tready) route_due_q.push_back(route_apply(in_tdata));
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("binary_trie_prefix_table test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, nested routes, host routes at both address
    // extremes, over-long and zero-length prefixes, zero hop, withdraw on a
    // missing or partial path, and clear picking up the default port.
    write_default_port(16'hFFFF);
    queue_item(OP_LOOKUP,   32'h0000_0000, 6'd0,  16'h0000);
    queue_item(OP_WITHDRAW, 32'h0A00_0000, 6'd8,  16'h0000);
    queue_item(OP_ANNOUNCE, 32'h0A00_0000, 6'd8,  16'h0001);
    queue_item(OP_ANNOUNCE, 32'h0A0B_0000, 6'd16, 16'hFFFF);
    queue_item(OP_LOOKUP,   32'h0A0B_0C0D, 6'd0,  16'h0000);
    queue_item(OP_LOOKUP,   32'h0AFF_0000, 6'd0,  16'h0000);
    queue_item(OP_ANNOUNCE, 32'hFFFF_FFFF, 6'd32, 16'h8001);
    queue_item(OP_LOOKUP,   32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    queue_item(OP_LOOKUP,   32'hFFFF_FFFE, 6'd0,  16'h0000);
    queue_item(OP_ANNOUNCE, 32'h0000_0000, 6'd63, 16'h1234);
    queue_item(OP_LOOKUP,   32'h0000_0000, 6'd0,  16'h0000);
    queue_item(OP_WITHDRAW, 32'h0000_0000, 6'd40, 16'h0000);
    queue_item(OP_LOOKUP,   32'h0000_0000, 6'd0,  16'h0000);
    queue_item(OP_ANNOUNCE, 32'h0000_0000, 6'd0,  16'h5555);
    queue_item(OP_LOOKUP,   32'hC000_0000, 6'd0,  16'h0000);
    queue_item(OP_WITHDRAW, 32'hFFFF_FFFF, 6'd0,  16'hFFFF);
    queue_item(OP_ANNOUNCE, 32'h0A00_0000, 6'd8,  16'h0000);
    queue_item(OP_WITHDRAW, 32'h0A0B_0C00, 6'd24, 16'h0000);
    queue_item(OP_CLEAR,    32'h0000_0000, 6'd0,  16'h0000);
    queue_item(OP_LOOKUP,   32'h1234_5678, 6'd0,  16'h0000);
    queue_item(OP_WITHDRAW, 32'h0A00_0000, 6'd8,  16'h0000);
    queue_item(OP_ANNOUNCE, 32'hAAAA_AAAA, 6'd33, 16'hAAAA);
    queue_item(OP_LOOKUP,   32'h5555_5555, 6'd0,  16'h0000);
    queue_item(OP_LOOKUP,   32'hAAAA_AAAA, 6'd0,  16'h0000);
    wait_drained();

    // Random phases; the fill phase keeps the nodes left over and runs the
    // pool dry, the next one clears it again.
    run_phase(MIX_ROUTES, 150, 16'h0000, 1'b1);
    run_phase(MIX_FILL,   240, HOP_W'($urandom), 1'b0);
    run_phase(MIX_ROUTES, 120, 16'h0001, 1'b1);
    calm = 1'b1;
    run_phase(MIX_ROUTES, 80, HOP_W'($urandom), 1'b1);

    if (route_due_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", route_due_q.size()));
    if (err_cnt == 0) begin
      $display("binary_trie_prefix_table test passed");
    end else begin
      $display("binary_trie_prefix_table test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/btpt_pkg.sv
hw/rtl/binary_trie_prefix_table.sv
tb/sv/binary_trie_prefix_table_tb.sv
